FILE: hdl/clm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_pkg
// Shared codes and the result descriptor of the caching lock manager.
// ----------------------------------------------------------------------------
package clm_pkg;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		KIND_REPLY  = 2'd0,
		KIND_REVOKE = 2'd1,
		KIND_RETRY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RETRY     = 3'd1,
		ST_NOENT     = 3'd2,
		ST_NOTOWNER  = 3'd3,
		ST_TABLEFULL = 3'd4,
		ST_QUEUEFULL = 3'd5
	} status_t;

	typedef struct packed {
		logic        retry;
		logic        revoke;
		logic [7:0]  retry_tgt;
		logic [7:0]  revoke_tgt;
		status_t     status;
		logic [7:0]  requester;
		logic [31:0] lock_id;
		logic [31:0] count;
	} clm_msg_t;

endpackage

FILE: hdl/clm_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clm_emit
// Result sequencer: sends retry, revoke and reply words of one request.
// ----------------------------------------------------------------------------
module clm_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  clm_pkg::clm_msg_t msg,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [2:0]        status,
	output logic [7:0]        target_client,
	output logic [31:0]       msg_lock_id,
	output logic signed [31:0] acquire_count,
	output logic              last
);
	import clm_pkg::*;

	clm_msg_t msg_q;
	logic     busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (busy_q && out_ready && !msg_q.retry && !msg_q.revoke) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			msg_q <= msg;
		end else if (busy_q && out_ready) begin
			if (msg_q.retry) begin
				msg_q.retry <= 1'b0;
			end else if (msg_q.revoke) begin
				msg_q.revoke <= 1'b0;
			end
		end
	end

	always_comb begin
		if (msg_q.retry) begin
			kind          = KIND_RETRY;
			status        = ST_OK;
			target_client = msg_q.retry_tgt;
			last          = 1'b0;
		end else if (msg_q.revoke) begin
			kind          = KIND_REVOKE;
			status        = ST_OK;
			target_client = msg_q.revoke_tgt;
			last          = 1'b0;
		end else begin
			kind          = KIND_REPLY;
			status        = msg_q.status;
			target_client = msg_q.requester;
			last          = 1'b1;
		end
	end

	assign busy          = busy_q;
	assign out_valid     = busy_q;
	assign msg_lock_id   = msg_q.lock_id;
	assign acquire_count = msg_q.count;

endmodule

FILE: hdl/caching_lock_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caching_lock_manager
// Lock table with owner, waiter FIFO, revoke and retry messages.
// ----------------------------------------------------------------------------
// One request is handled at a time. The lock table is searched by a single
// identifier comparator, one allocated entry at a time in allocation order
// through a read state and a compare state, until a match or, on a miss,
// until all allocated entries are compared. Entries are allocated in order
// and never removed, so a fill count stands for the valid bits and no
// clearing pass follows reset.
module caching_lock_manager #(
	parameter int LOCK_ENTRIES = 16,
	parameter int QUEUE_DEPTH  = 8,
	parameter int CLIENT_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [31:0]        lock_id,
	input  logic [7:0]         client_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [2:0]         status,
	output logic [7:0]         target_client,
	output logic [31:0]        msg_lock_id,
	output logic signed [31:0] acquire_count,
	output logic               last
);
	import clm_pkg::*;

	localparam int EB  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
	localparam int FB  = $clog2(LOCK_ENTRIES + 1);
	localparam int QB  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NB  = $clog2(QUEUE_DEPTH + 1);
	localparam int WN  = LOCK_ENTRIES * QUEUE_DEPTH;
	localparam int WB  = (WN > 1) ? $clog2(WN) : 1;
	localparam int CW  = (CLIENT_BITS < 8) ? CLIENT_BITS : 8;

	typedef struct packed {
		logic          locked;
		logic [CW-1:0] owner;
		logic [QB-1:0] head;
		logic [NB-1:0] cnt;
	} ent_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_CMP   = 6'b000100,
		S_EXEC  = 6'b001000,
		S_HAND  = 6'b010000,
		S_DRAIN = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic          op_q;
	logic [31:0]   lid_q;
	logic [CW-1:0] cid_q;
	logic [31:0]   cnt_q;
	logic [FB-1:0] fill_q;
	logic [FB-1:0] idx_q;

	logic [31:0]   lid_mem [LOCK_ENTRIES];
	ent_t          ent_mem [LOCK_ENTRIES];
	logic [CW-1:0] wait_mem [WN];
	logic [31:0]   rd_lid_q;
	ent_t          rd_ent_q;
	logic [CW-1:0] rd_w_q;

	logic          lid_we, ent_we, w_we, fill_inc, idx_inc, load;
	logic [EB-1:0] ent_wa;
	ent_t          ent_wd;
	logic [WB-1:0] w_addr;
	logic [QB:0]   pos_sum, pos, head_inc, head_nxt;
	logic [NB-1:0] cnt_dec;
	clm_msg_t      msg;
	logic          emit_busy;

	assign pos_sum  = (QB+1)'(rd_ent_q.head) + (QB+1)'(rd_ent_q.cnt);
	assign pos      = (pos_sum >= (QB+1)'(QUEUE_DEPTH)) ?
	                  pos_sum - (QB+1)'(QUEUE_DEPTH) : pos_sum;
	assign head_inc = (QB+1)'(rd_ent_q.head) + (QB+1)'(1);
	assign head_nxt = (head_inc >= (QB+1)'(QUEUE_DEPTH)) ? '0 : head_inc;
	assign cnt_dec  = rd_ent_q.cnt - NB'(1);

	always_comb begin
		state_d  = state_q;
		lid_we   = 1'b0;
		ent_we   = 1'b0;
		w_we     = 1'b0;
		fill_inc = 1'b0;
		idx_inc  = 1'b0;
		load     = 1'b0;
		ent_wa   = idx_q[EB-1:0];
		ent_wd   = rd_ent_q;
		w_addr   = WB'(idx_q[EB-1:0]) * WB'(QUEUE_DEPTH) + WB'(rd_ent_q.head);
		msg.retry      = 1'b0;
		msg.revoke     = 1'b0;
		msg.retry_tgt  = 8'(rd_w_q);
		msg.revoke_tgt = 8'(rd_ent_q.owner);
		msg.status     = ST_OK;
		msg.requester  = 8'(cid_q);
		msg.lock_id    = lid_q;
		msg.count      = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (idx_q == fill_q) begin
					load    = 1'b1;
					state_d = S_DRAIN;
					if (op_q == OP_RELEASE) begin
						msg.status = ST_NOENT;
					end else if (fill_q == FB'(LOCK_ENTRIES)) begin
						msg.status = ST_TABLEFULL;
					end else begin
						lid_we        = 1'b1;
						ent_we        = 1'b1;
						fill_inc      = 1'b1;
						ent_wa        = fill_q[EB-1:0];
						ent_wd.locked = 1'b1;
						ent_wd.owner  = cid_q;
						ent_wd.head   = '0;
						ent_wd.cnt    = '0;
					end
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (rd_lid_q == lid_q) begin
					state_d = S_EXEC;
				end else begin
					idx_inc = 1'b1;
					state_d = S_READ;
				end
			end
			S_EXEC: begin
				if (op_q == OP_ACQUIRE) begin
					load    = 1'b1;
					state_d = S_DRAIN;
					if (!rd_ent_q.locked) begin
						ent_we        = 1'b1;
						ent_wd.locked = 1'b1;
						ent_wd.owner  = cid_q;
					end else if (rd_ent_q.cnt == NB'(QUEUE_DEPTH)) begin
						msg.status = ST_QUEUEFULL;
					end else begin
						w_we       = 1'b1;
						w_addr     = WB'(idx_q[EB-1:0]) * WB'(QUEUE_DEPTH) + WB'(pos);
						ent_we     = 1'b1;
						ent_wd.cnt = rd_ent_q.cnt + NB'(1);
						msg.revoke = (rd_ent_q.cnt == '0);
						msg.status = ST_RETRY;
					end
				end else if (!rd_ent_q.locked || rd_ent_q.owner != cid_q) begin
					load       = 1'b1;
					state_d    = S_DRAIN;
					msg.status = ST_NOTOWNER;
				end else if (rd_ent_q.cnt == '0) begin
					load          = 1'b1;
					state_d       = S_DRAIN;
					ent_we        = 1'b1;
					ent_wd.locked = 1'b0;
				end else begin
					state_d = S_HAND;
				end
			end
			S_HAND: begin
				load           = 1'b1;
				state_d        = S_DRAIN;
				ent_we         = 1'b1;
				ent_wd.owner   = rd_w_q;
				ent_wd.head    = head_nxt[QB-1:0];
				ent_wd.cnt     = cnt_dec;
				msg.retry      = 1'b1;
				msg.revoke     = (cnt_dec != '0);
				msg.revoke_tgt = 8'(rd_w_q);
			end
			S_DRAIN: begin
				if (!emit_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid) begin
				cnt_q <= (opcode == OP_ACQUIRE) ? cnt_q + 32'd1 : cnt_q - 32'd1;
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + FB'(1);
			end
			if (fill_inc) begin
				fill_q <= fill_q + FB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q  <= opcode;
			lid_q <= lock_id;
			cid_q <= client_id[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (lid_we) begin
			lid_mem[fill_q[EB-1:0]] <= lid_q;
		end
		rd_lid_q <= lid_mem[idx_q[EB-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		rd_ent_q <= ent_mem[idx_q[EB-1:0]];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wait_mem[w_addr] <= cid_q;
		end
		rd_w_q <= wait_mem[w_addr];
	end

	assign in_ready = (state_q == S_IDLE);

	clm_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.msg           (msg),
		.busy          (emit_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.status        (status),
		.target_client (target_client),
		.msg_lock_id   (msg_lock_id),
		.acquire_count (acquire_count),
		.last          (last)
	);

endmodule
